// ----- hdl/radix_prefixed_integer_parser_unit_assert.svh -----
// Assertion shorthands for the integer parser unit.
// Each expects i_clk and i_rst_n in scope.
`ifndef RADIX_PREFIXED_INTEGER_PARSER_UNIT_ASSERT_SVH
`define RADIX_PREFIXED_INTEGER_PARSER_UNIT_ASSERT_SVH

// Condition holds at every edge out of reset.
`define RPIP_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define RPIP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rpip_pkg.sv -----
`timescale 1ns / 1ps
package rpip_pkg;

    localparam int MAX_LEN     = 4095;
    localparam int POS_W       = $clog2(MAX_LEN + 1);
    localparam int SAT_W       = $clog2(MAX_LEN + 2);
    localparam int CODE_W      = 13;
    localparam int VALUE_W     = 64;
    localparam int MAG_W       = VALUE_W - 1;
    localparam int DIGIT_W     = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int OBUF_DEPTH  = 2;

    // Character classes produced by the front end.
    typedef enum logic [3:0] {
        CLS_BLANK,
        CLS_PLUS,
        CLS_MINUS,
        CLS_MINUS_BAD,
        CLS_DOLLAR,
        CLS_X,
        CLS_AMP,
        CLS_PCT,
        CLS_ZERO,
        CLS_OTHER
    } t_cls;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        RDX_DEC,
        RDX_HEX,
        RDX_OCT,
        RDX_BIN
    } t_radix;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_SIGN_POS,
        ACT_SIGN_NEG,
        ACT_FAIL_AFTER,
        ACT_HEX,
        ACT_OCT,
        ACT_BIN,
        ACT_ZERO,
        ACT_ZERO_HEX,
        ACT_DIGIT
    } t_act;

    // One classified character in flight between front and back.
    typedef struct packed {
        t_cls               cls;
        logic [DIGIT_W-1:0] digit;
        logic               dig_ok;
        logic               has_char;
        logic               last;
        logic [SAT_W-1:0]   code_at;     // position + 1, saturated
        logic [SAT_W-1:0]   code_after;  // position + 2, saturated
    } t_token;

endpackage

// ----- hdl/radix_prefixed_integer_parser_unit.sv -----
`timescale 1ns / 1ps
// Result path: the last item of a string passes the character queue, then the back end
// writes the result into the result buffer, clearing o_empty so it can be popped.
// Throughput: one character per cycle unless stalled; the multiply-add is combinational.
// A 4-entry character queue and a 2-entry result buffer absorb stalls on either side.
// Reset: i_rst_n is synchronous, active low; queues empty, parser back at leading blanks.
module radix_prefixed_integer_parser_unit import rpip_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [7:0]                i_ch,
    input  logic                      i_has_char,
    input  logic                      i_last,
    input  logic                      i_is_unsigned,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [CODE_W-1:0]         o_code
);

    t_token w_fe_token, w_be_token;
    logic   w_q_push, w_q_full, w_q_pop, w_q_empty;

    rpip_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_ch          (i_ch),
        .i_has_char    (i_has_char),
        .i_last        (i_last),
        .i_is_unsigned (i_is_unsigned),
        .o_full        (o_full),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_token       (w_fe_token)
    );

    rpip_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_fe_token),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_be_token),
        .o_empty (w_q_empty)
    );

    rpip_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_token   (w_be_token),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .o_value   (o_value),
        .o_code    (o_code),
        .o_empty   (o_empty),
        .i_pop     (i_pop)
    );

endmodule

// ----- hdl/rpip_front.sv -----
`timescale 1ns / 1ps
`include "radix_prefixed_integer_parser_unit_assert.svh"
module rpip_front import rpip_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_ch,
    input  logic       i_has_char,
    input  logic       i_last,
    input  logic       i_is_unsigned,
    output logic       o_full,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_token     o_token
);

    localparam int EXT_W = POS_W + 2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_unsigned, n_unsigned;
    logic             w_accept;
    logic             w_uns;
    logic [7:0]       w_dsub;
    logic [EXT_W-1:0] w_p1, w_p2;
    t_cls             w_cls;
    logic             w_dig_ok;

    assign o_full   = i_q_full;
    assign w_accept = i_push && !i_q_full;
    assign o_q_push = w_accept && (i_has_char || i_last);

    // unsigned mode is sampled on the first character of a string
    assign w_uns = (r_pos == '0) ? i_is_unsigned : r_unsigned;

    always_comb begin
        w_dig_ok = 1'b1;
        w_dsub   = i_ch - CH_0;
        if (i_ch >= CH_0 && i_ch <= CH_9) begin
            w_dsub = i_ch - CH_0;
        end else if (i_ch >= CH_LA && i_ch <= CH_LZ) begin
            w_dsub = i_ch - (CH_LA - 8'd10);
        end else if (i_ch >= CH_UA && i_ch <= CH_UZ) begin
            w_dsub = i_ch - (CH_UA - 8'd10);
        end else begin
            w_dig_ok = 1'b0;
        end
    end

    always_comb begin
        unique case (i_ch)
            CH_SPACE, CH_TAB, CH_CR, CH_LF: w_cls = CLS_BLANK;
            CH_PLUS:                        w_cls = CLS_PLUS;
            CH_MINUS:                       w_cls = w_uns ? CLS_MINUS_BAD : CLS_MINUS;
            CH_DOLLAR:                      w_cls = CLS_DOLLAR;
            CH_LX, CH_UX:                   w_cls = CLS_X;
            CH_AMP:                         w_cls = CLS_AMP;
            CH_PCT:                         w_cls = CLS_PCT;
            CH_0:                           w_cls = CLS_ZERO;
            default:                        w_cls = CLS_OTHER;
        endcase
    end

    assign w_p1 = EXT_W'(r_pos) + EXT_W'(1);
    assign w_p2 = EXT_W'(r_pos) + EXT_W'(2);

    always_comb begin
        o_token.cls      = w_cls;
        o_token.digit    = w_dsub[DIGIT_W-1:0];
        o_token.dig_ok   = w_dig_ok;
        o_token.has_char = i_has_char;
        o_token.last     = i_last;
        o_token.code_at  = SAT_W'(w_p1);
        o_token.code_after = (w_p2 > EXT_W'(MAX_LEN + 1)) ? SAT_W'(MAX_LEN + 1)
                                                          : SAT_W'(w_p2);
    end

    always_comb begin
        n_pos      = r_pos;
        n_unsigned = r_unsigned;
        if (w_accept) begin
            if (i_has_char && r_pos == '0) begin
                n_unsigned = i_is_unsigned;
            end
            if (i_last) begin
                n_pos = '0;
            end else if (i_has_char && r_pos != POS_W'(MAX_LEN)) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_unsigned <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_unsigned <= n_unsigned;
        end
    end

    `RPIP_ASSERT_NEXT(a_pos_clears_at_end, w_accept && i_last, r_pos == '0, "position not cleared")

endmodule

// ----- hdl/rpip_fifo.sv -----
`timescale 1ns / 1ps
`include "radix_prefixed_integer_parser_unit_assert.svh"
module rpip_fifo import rpip_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_token o_data,
    output logic   o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_token           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        unique case ({w_wr, w_rd})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    `RPIP_ASSERT_NEXT(a_q_count_up, w_wr && !w_rd, r_cnt == $past(r_cnt) + CNT_W'(1), "queue count")

endmodule

// ----- hdl/rpip_back.sv -----
`timescale 1ns / 1ps
`include "radix_prefixed_integer_parser_unit_assert.svh"
module rpip_back import rpip_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_token                    i_token,
    input  logic                      i_q_empty,
    output logic                      o_q_pop,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [CODE_W-1:0]         o_code,
    output logic                      o_empty,
    input  logic                      i_pop
);

    localparam int OPTR_W = $clog2(OBUF_DEPTH);
    localparam int OCNT_W = $clog2(OBUF_DEPTH + 1);
    localparam int PROD_W = MAG_W + 4;

    t_phase             r_phase, n_phase;
    t_radix             r_radix, n_radix;
    logic               r_neg, n_neg;
    logic [MAG_W-1:0]   r_mag, n_mag;
    logic               r_dnz, n_dnz;
    logic               r_fail, n_fail;
    logic [SAT_W-1:0]   r_code, n_code;

    logic [VALUE_W-1:0] r_obuf_val  [OBUF_DEPTH];
    logic [CODE_W-1:0]  r_obuf_code [OBUF_DEPTH];
    logic [OPTR_W-1:0]  r_owptr, n_owptr;
    logic [OPTR_W-1:0]  r_orptr, n_orptr;
    logic [OCNT_W-1:0]  r_ocnt, n_ocnt;

    t_act               w_act;
    logic               w_step, w_emit, w_opop;
    logic [DIGIT_W-1:0] w_limit;
    logic               w_dig_valid;
    logic [PROD_W-1:0]  w_prod, w_sum;
    logic               w_ovf;
    logic [SAT_W-1:0]   w_end_code;
    logic [SAT_W-1:0]   w_res_code;
    logic [VALUE_W-1:0] w_res_val;

    assign w_step  = !i_q_empty && (r_ocnt != OCNT_W'(OBUF_DEPTH));
    assign o_q_pop = w_step;
    assign w_emit  = w_step && i_token.last;
    assign w_opop  = i_pop && !o_empty;

    // decode what this character does in the current phase
    always_comb begin
        w_act = ACT_NONE;
        if (w_step && i_token.has_char && !r_fail) begin
            unique case (r_phase)
                PH_LEAD, PH_PREFIX: begin
                    unique case (i_token.cls)
                        CLS_BLANK:     w_act = (r_phase == PH_LEAD) ? ACT_NONE : ACT_DIGIT;
                        CLS_PLUS:      w_act = (r_phase == PH_LEAD) ? ACT_SIGN_POS : ACT_DIGIT;
                        CLS_MINUS:     w_act = (r_phase == PH_LEAD) ? ACT_SIGN_NEG : ACT_DIGIT;
                        CLS_MINUS_BAD: w_act = (r_phase == PH_LEAD) ? ACT_FAIL_AFTER : ACT_DIGIT;
                        CLS_DOLLAR, CLS_X: w_act = ACT_HEX;
                        CLS_AMP:       w_act = ACT_OCT;
                        CLS_PCT:       w_act = ACT_BIN;
                        CLS_ZERO:      w_act = ACT_ZERO;
                        default:       w_act = ACT_DIGIT;
                    endcase
                end
                PH_ZERO:   w_act = (i_token.cls == CLS_X) ? ACT_ZERO_HEX : ACT_DIGIT;
                PH_DIGITS: w_act = ACT_DIGIT;
                default:   w_act = ACT_DIGIT;
            endcase
        end
    end

    // next phase
    always_comb begin
        unique case (w_act)
            ACT_SIGN_POS, ACT_SIGN_NEG:                   n_phase = PH_PREFIX;
            ACT_ZERO:                                     n_phase = PH_ZERO;
            ACT_HEX, ACT_OCT, ACT_BIN, ACT_ZERO_HEX,
            ACT_DIGIT:                                    n_phase = PH_DIGITS;
            default:                                      n_phase = r_phase;
        endcase
    end

    always_comb begin
        unique case (r_radix)
            RDX_HEX: w_limit = DIGIT_W'(16);
            RDX_OCT: w_limit = DIGIT_W'(8);
            RDX_BIN: w_limit = DIGIT_W'(2);
            default: w_limit = DIGIT_W'(10);
        endcase
    end

    // magnitude * radix + digit; anything above bit MAG_W-1 is overflow
    always_comb begin
        unique case (r_radix)
            RDX_HEX: w_prod = {r_mag, 4'b0000};
            RDX_OCT: w_prod = PROD_W'({r_mag, 3'b000});
            RDX_BIN: w_prod = PROD_W'({r_mag, 1'b0});
            default: w_prod = PROD_W'({r_mag, 3'b000}) + PROD_W'({r_mag, 1'b0});
        endcase
    end

    assign w_sum       = w_prod + PROD_W'(i_token.digit);
    assign w_ovf       = |w_sum[PROD_W-1:MAG_W];
    assign w_dig_valid = i_token.dig_ok && (i_token.digit < w_limit);

    // datapath update
    always_comb begin
        n_radix = r_radix;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_dnz   = r_dnz;
        n_fail  = r_fail;
        n_code  = r_code;
        unique case (w_act)
            ACT_SIGN_NEG:   n_neg = 1'b1;
            ACT_FAIL_AFTER: begin
                n_fail = 1'b1;
                n_code = i_token.code_after;
            end
            ACT_HEX:        n_radix = RDX_HEX;
            ACT_OCT:        n_radix = RDX_OCT;
            ACT_BIN:        n_radix = RDX_BIN;
            ACT_ZERO: begin
                n_dnz = 1'b1;
                n_mag = '0;
            end
            ACT_ZERO_HEX: begin
                n_radix = RDX_HEX;
                n_dnz   = 1'b0;
            end
            ACT_DIGIT: begin
                if (!w_dig_valid || w_ovf) begin
                    n_fail = 1'b1;
                    n_code = i_token.code_at;
                end else begin
                    n_mag = w_sum[MAG_W-1:0];
                    n_dnz = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // end of string: with a character the length is one past this position
    assign w_end_code = i_token.has_char ? i_token.code_after : i_token.code_at;

    always_comb begin
        w_res_val  = '0;
        w_res_code = '0;
        if (n_fail) begin
            w_res_code = n_code;
        end else if (!n_dnz) begin
            w_res_code = w_end_code;
        end else begin
            w_res_val = n_neg ? (VALUE_W'(0) - VALUE_W'(n_mag)) : VALUE_W'(n_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_radix <= RDX_DEC;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_dnz   <= 1'b0;
            r_fail  <= 1'b0;
            r_code  <= '0;
        end else if (w_emit) begin
            r_phase <= PH_LEAD;
            r_radix <= RDX_DEC;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_dnz   <= 1'b0;
            r_fail  <= 1'b0;
            r_code  <= '0;
        end else begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_dnz   <= n_dnz;
            r_fail  <= n_fail;
            r_code  <= n_code;
        end
    end

    // result buffer
    assign o_empty = (r_ocnt == '0);
    assign o_value = r_obuf_val[r_orptr];
    assign o_code  = r_obuf_code[r_orptr];

    always_comb begin
        n_owptr = r_owptr;
        n_orptr = r_orptr;
        if (w_emit) begin
            n_owptr = (r_owptr == OPTR_W'(OBUF_DEPTH - 1)) ? '0 : r_owptr + OPTR_W'(1);
        end
        if (w_opop) begin
            n_orptr = (r_orptr == OPTR_W'(OBUF_DEPTH - 1)) ? '0 : r_orptr + OPTR_W'(1);
        end
        unique case ({w_emit, w_opop})
            2'b10:   n_ocnt = r_ocnt + OCNT_W'(1);
            2'b01:   n_ocnt = r_ocnt - OCNT_W'(1);
            default: n_ocnt = r_ocnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_obuf_val[r_owptr]  <= w_res_val;
            r_obuf_code[r_owptr] <= CODE_W'(w_res_code);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owptr <= '0;
            r_orptr <= '0;
            r_ocnt  <= '0;
        end else begin
            r_owptr <= n_owptr;
            r_orptr <= n_orptr;
            r_ocnt  <= n_ocnt;
        end
    end

    `RPIP_ASSERT_NEXT(a_string_end_clears, w_emit, r_phase == PH_LEAD && !r_fail && !r_dnz, "state not cleared")
    `RPIP_ASSERT_HOLDS(a_fail_code_set, !r_fail || r_code != '0, "failure without position")
    `RPIP_ASSERT_HOLDS(a_obuf_bound, r_ocnt <= OCNT_W'(OBUF_DEPTH), "result buffer overrun")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench import rpip_pkg::*; ();

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int ITEM_TARGET  = 1950;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 400;

    localparam bit [63:0] MAG_CEILING = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam bit [7:0] CH_SPACE  = 8'h20;
    localparam bit [7:0] CH_TAB    = 8'h09;
    localparam bit [7:0] CH_CR     = 8'h0D;
    localparam bit [7:0] CH_LF     = 8'h0A;
    localparam bit [7:0] CH_PLUS   = "+";
    localparam bit [7:0] CH_MINUS  = "-";
    localparam bit [7:0] CH_DOLLAR = "$";
    localparam bit [7:0] CH_AMP    = "&";
    localparam bit [7:0] CH_PCT    = "%";
    localparam bit [7:0] CH_ZERO   = "0";
    localparam bit [7:0] CH_NINE   = "9";
    localparam bit [7:0] CH_LX     = "x";
    localparam bit [7:0] CH_UX     = "X";
    localparam bit [7:0] CH_LA     = "a";
    localparam bit [7:0] CH_LZ     = "z";
    localparam bit [7:0] CH_UA     = "A";
    localparam bit [7:0] CH_UZ     = "Z";

    typedef struct {
        bit [VALUE_W-1:0] value;
        bit [CODE_W-1:0]  code;
    } t_parse_result;

    // Tracks the parse of the string in flight and holds the results still owed.
    class t_parse_tracker;
        t_phase     phase;
        int         pos;
        bit         negative;
        t_radix     radix;
        bit [63:0]  mag;
        bit         have_digits;
        bit         failed;
        int         fail_pos;
        bit         unsigned_mode;
        t_parse_result expected_parses[$];
        int         errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase         = PH_LEAD;
            pos           = 0;
            negative      = 1'b0;
            radix         = RDX_DEC;
            mag           = '0;
            have_digits   = 1'b0;
            failed        = 1'b0;
            fail_pos      = 0;
            unsigned_mode = 1'b0;
        endfunction

        function int sat(int c);
            return (c > MAX_LEN + 1) ? MAX_LEN + 1 : c;
        endfunction

        function void fail(int c);
            failed   = 1'b1;
            fail_pos = sat(c);
        endfunction

        function int radix_base();
            case (radix)
                RDX_HEX: return 16;
                RDX_OCT: return 8;
                RDX_BIN: return 2;
                default: return 10;
            endcase
        endfunction

        function int digit_of(bit [7:0] c);
            int d;
            if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
            else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + 10;
            else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + 10;
            else return -1;
            return (d < radix_base()) ? d : -1;
        endfunction

        function void take_digit(bit [7:0] c, int p);
            bit [63:0] r;
            int d;
            r = 64'(radix_base());
            d = digit_of(c);
            if (d < 0) begin
                fail(p + 1);
                return;
            end
            // would pass the largest signed 64-bit value
            if (mag > (MAG_CEILING - 64'(d)) / r) begin
                fail(p + 1);
                return;
            end
            mag = mag * r + 64'(d);
            have_digits = 1'b1;
        endfunction

        function void take_prefix(bit [7:0] c, int p);
            if (c == CH_DOLLAR || c == CH_LX || c == CH_UX) begin
                radix = RDX_HEX;
                phase = PH_DIGITS;
            end else if (c == CH_AMP) begin
                radix = RDX_OCT;
                phase = PH_DIGITS;
            end else if (c == CH_PCT) begin
                radix = RDX_BIN;
                phase = PH_DIGITS;
            end else if (c == CH_ZERO) begin
                phase       = PH_ZERO;
                have_digits = 1'b1;
                mag         = '0;
            end else begin
                phase = PH_DIGITS;
                take_digit(c, p);
            end
        endfunction

        function void take_char(bit [7:0] c, int p);
            if (failed) return;
            case (phase)
                PH_LEAD: begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) return;
                    if (c == CH_PLUS) begin
                        phase = PH_PREFIX;
                    end else if (c == CH_MINUS) begin
                        if (unsigned_mode) begin
                            fail(p + 2);
                        end else begin
                            negative = 1'b1;
                            phase    = PH_PREFIX;
                        end
                    end else begin
                        take_prefix(c, p);
                    end
                end
                PH_PREFIX: take_prefix(c, p);
                PH_ZERO: begin
                    if (c == CH_LX || c == CH_UX) begin
                        radix       = RDX_HEX;
                        have_digits = 1'b0;
                        phase       = PH_DIGITS;
                    end else begin
                        phase = PH_DIGITS;
                        take_digit(c, p);
                    end
                end
                default: take_digit(c, p);
            endcase
        endfunction

        function void take_char_item(bit [7:0] ch, bit has, bit last, bit uns);
            t_parse_result r;
            if (has) begin
                if (pos == 0) unsigned_mode = uns;
                take_char(ch, pos);
                if (pos < MAX_LEN) pos++;
            end
            if (!last) return;
            r.value = '0;
            if (failed) begin
                r.code = CODE_W'(fail_pos);
            end else if (!have_digits) begin
                r.code = CODE_W'(sat(pos + 1));
            end else begin
                r.code  = '0;
                r.value = negative ? -mag : mag;
            end
            expected_parses.push_back(r);
            clear();
        endfunction

        function void match_parse(logic [VALUE_W-1:0] value, logic [CODE_W-1:0] code);
            t_parse_result e;
            if (expected_parses.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, value %0d code %0d", $time,
                         $signed(value), code);
                return;
            end
            e = expected_parses.pop_front();
            if (value !== e.value) begin
                errors++;
                $display("%0t: value mismatch, expected %0d, actual %0d", $time,
                         $signed(e.value), $signed(value));
            end
            if (code !== e.code) begin
                errors++;
                $display("%0t: code mismatch, expected %0d, actual %0d", $time, e.code, code);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_push = 1'b0;
    logic                      o_full;
    logic [7:0]                i_ch = '0;
    logic                      i_has_char = 1'b0;
    logic                      i_last = 1'b0;
    logic                      i_is_unsigned = 1'b0;
    logic                      o_empty;
    logic                      i_pop = 1'b0;
    logic signed [VALUE_W-1:0] o_value;
    logic [CODE_W-1:0]         o_code;

    t_parse_tracker tracker;
    int snd_idle_pct = 9;
    int rcv_idle_pct = 69;
    int items_sent = 0;
    int cycle_count = 0;

    radix_prefixed_integer_parser_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_ch          (i_ch),
        .i_has_char    (i_has_char),
        .i_last        (i_last),
        .i_is_unsigned (i_is_unsigned),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_value       (o_value),
        .o_code        (o_code)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(bit [7:0] ch, bit has, bit last, bit uns);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_ch          <= ch;
        i_has_char    <= has;
        i_last        <= last;
        i_is_unsigned <= uns;
        i_push        <= 1'b1;
        do @(posedge i_clk); while (o_full !== 1'b0);
        tracker.take_char_item(ch, has, last, uns);
        items_sent++;
    endtask

    task automatic send_string(string s, bit uns);
        int n;
        bit bare_end;
        n = s.len();
        bare_end = (n == 0) || ($urandom_range(9) == 0);
        for (int i = 0; i < n; i++) begin
            // ignored transaction: no char, no last
            if ($urandom_range(19) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'($urandom_range(1)));
            send_item(s[i], 1'b1, (i == n - 1) && !bare_end,
                      (i == 0) ? uns : 1'($urandom_range(1)));
        end
        if (bare_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1, uns);
    endtask

    function automatic bit [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic string digits_of(bit [63:0] v, int base);
        string s;
        bit [63:0] x;
        int d;
        bit [7:0] c;
        s = "";
        x = v;
        do begin
            d = int'(x % 64'(base));
            x = x / 64'(base);
            if (d < 10) c = CH_ZERO + 8'(d);
            else c = ($urandom_range(1) ? CH_LA : CH_UA) + 8'(d - 10);
            s = $sformatf("%c%s", c, s);
        end while (x != 0);
        return s;
    endfunction

    function automatic string make_number();
        string s;
        bit [63:0] m;
        t_radix rdx;
        int base;
        s = "";
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) s = $sformatf("%s%c", s, pick_blank());
        case ($urandom_range(3))
            0:       s = $sformatf("%s%c", s, CH_PLUS);
            1:       s = $sformatf("%s%c", s, CH_MINUS);
            default: ;
        endcase
        rdx = t_radix'($urandom_range(3));
        case (rdx)
            RDX_HEX: begin
                base = 16;
                case ($urandom_range(4))
                    0:       s = $sformatf("%s%c", s, CH_DOLLAR);
                    1:       s = $sformatf("%s%c", s, CH_LX);
                    2:       s = $sformatf("%s%c", s, CH_UX);
                    3:       s = $sformatf("%s%c%c", s, CH_ZERO, CH_LX);
                    default: s = $sformatf("%s%c%c", s, CH_ZERO, CH_UX);
                endcase
            end
            RDX_OCT: begin
                base = 8;
                s = $sformatf("%s%c", s, CH_AMP);
            end
            RDX_BIN: begin
                base = 2;
                s = $sformatf("%s%c", s, CH_PCT);
            end
            default: base = 10;
        endcase
        case ($urandom_range(9))
            0:       m = MAG_CEILING;
            1:       m = MAG_CEILING + 64'd1;
            2:       m = {$urandom, $urandom};
            3:       m = '0;
            4, 5:    m = 64'($urandom_range(999));
            default: m = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        if ($urandom_range(7) == 0) s = $sformatf("%s%c", s, CH_ZERO);
        return {s, digits_of(m, base)};
    endfunction

    function automatic string make_noise();
        string pool;
        string s;
        bit [7:0] c;
        pool = "+-$&%0xX \t9aZg7";
        s = "";
        repeat ($urandom_range(6)) begin
            if ($urandom_range(1)) c = 8'($urandom_range(255));
            else c = pool[$urandom_range(pool.len() - 1)];
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    task automatic send_random_string();
        string s;
        int sel;
        int n;
        sel = $urandom_range(99);
        if (sel < 60) begin
            s = make_number();
        end else if (sel < 80) begin
            s = make_number();
            n = s.len();
            case ($urandom_range(2))
                0: s[$urandom_range(n - 1)] = 8'($urandom_range(255));
                1: begin
                    n = $urandom_range(n - 1);
                    s = (n == 0) ? "" : s.substr(0, n - 1);
                end
                default: s = $sformatf("%s%c", s,
                                       $urandom_range(1) ? pick_blank() : 8'($urandom_range(255)));
            endcase
        end else begin
            s = make_noise();
        end
        send_string(s, 1'($urandom_range(1)));
    endtask

    task automatic send_directed();
        string texts[13];
        bit uns_flags[13];
        texts = '{"", "0", "0x", "-1", "-1", "+%1", "&7", "$aF", "12 ",
                  "\t\015\n-", "08", "9z", "0xg"};
        uns_flags = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                      1'b0, 1'b0, 1'b0, 1'b0};
        foreach (texts[i]) send_string(texts[i], uns_flags[i]);
    endtask

    task automatic pop_results();
        int n_popped;
        int hold_at;
        n_popped = 0;
        hold_at  = 30;
        forever begin
            // long receiver stall so the input side backs up
            if (n_popped == hold_at) begin
                hold_at += 170;
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_pop <= ($urandom_range(99) >= rcv_idle_pct);
            @(posedge i_clk);
            if (i_pop && o_empty === 1'b0) begin
                tracker.match_parse(o_value, o_code);
                n_popped++;
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            pop_results();
        join_none

        send_directed();
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 2 * ITEM_TARGET / 3) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end else if (items_sent >= ITEM_TARGET / 3) begin
                snd_idle_pct = 69;
                rcv_idle_pct = 9;
            end
            send_random_string();
        end
        i_push <= 1'b0;

        while (tracker.expected_parses.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.expected_parses.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rpip_pkg.sv
hdl/rpip_front.sv
hdl/rpip_fifo.sv
hdl/rpip_back.sv
hdl/radix_prefixed_integer_parser_unit.sv
sim/testbench.sv
